// File: design/rkct_pkg.sv
package rkct_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int OCC_BITS   = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_COUNTED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_ABSENT   = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   localparam logic REQ_INC = 1'b0;
   localparam logic REQ_DEC = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] key;
   } req_type_s_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        nonempty;
      logic [31:0] max_key;
      logic [31:0] min_key;
      logic [15:0] max_count;
   } rsp_type_s_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_UPDATE
   } op_type;

   typedef struct packed {
      logic found;
      logic full;
      logic at_limit;
      logic last_one;
   } dp_status_type;

endpackage

// File: design/rkct_datapath.sv
module rkct_datapath
   import rkct_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  op_type         op,
   input  req_type_s_type req,
   output dp_status_type  stat,
   output rsp_type_s_type view
);

   logic [KEY_BITS-1:0]   key_ff [ENTRIES];
   logic [COUNT_BITS-1:0] cnt_ff [ENTRIES];
   logic [KEY_BITS-1:0]   key_in [ENTRIES];
   logic [COUNT_BITS-1:0] cnt_in [ENTRIES];
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   logic                  type_ff;
   logic [KEY_BITS-1:0]   rkey_ff;
   logic [ENTRIES-1:0]    hit_ff, hit_in;
   logic [IDX_BITS-1:0]   pos;
   logic [COUNT_BITS-1:0] c, nc;
   logic [ENTRIES-1:0]    ahead, behind;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++)
         hit_in[i] = (OCC_BITS'(i) < occ_ff) && (key_ff[i] == KEY_BITS'(req.key));
   end

   always_comb begin
      pos = '0;
      for (int i = ENTRIES-1; i >= 0; i--)
         if (hit_ff[i]) pos = IDX_BITS'(i);
   end

   assign c  = cnt_ff[pos];
   assign nc = (type_ff == REQ_INC) ? c + 1'b1 : c - 1'b1;

   assign stat.found    = |hit_ff;
   assign stat.full     = (occ_ff == OCC_BITS'(ENTRIES));
   assign stat.at_limit = (c == '1);
   assign stat.last_one = (c <= COUNT_BITS'(1));

   // ahead[i]: cell i ends up ahead of the moved key
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         ahead[i]  = (cnt_ff[i] >= nc);
         behind[i] = (cnt_ff[i] <= nc);
      end
   end

   always_comb begin
      int tgt;
      tgt = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i] = key_ff[i];
         cnt_in[i] = cnt_ff[i];
      end
      occ_in = occ_ff;
      if (op == OP_UPDATE) begin
         if (!(|hit_ff)) begin
            if (type_ff == REQ_INC && occ_ff != OCC_BITS'(ENTRIES)) begin
               key_in[occ_ff[IDX_BITS-1:0]] = rkey_ff;
               cnt_in[occ_ff[IDX_BITS-1:0]] = COUNT_BITS'(1);
               occ_in = occ_ff + 1'b1;
            end
         end else if (type_ff == REQ_DEC && c <= COUNT_BITS'(1)) begin
            for (int i = 0; i < ENTRIES-1; i++)
               if (i >= int'(pos)) begin
                  key_in[i] = key_ff[i+1];
                  cnt_in[i] = cnt_ff[i+1];
               end
            occ_in = occ_ff - 1'b1;
         end else if (type_ff == REQ_INC && c != '1) begin
            tgt = int'(pos);
            for (int i = ENTRIES-1; i >= 0; i--)
               if (i < int'(pos) && !ahead[i]) tgt = i;
            for (int i = 1; i < ENTRIES; i++)
               if (i > tgt && i <= int'(pos)) begin
                  key_in[i] = key_ff[i-1];
                  cnt_in[i] = cnt_ff[i-1];
               end
            key_in[tgt] = rkey_ff;
            cnt_in[tgt] = nc;
         end else if (type_ff == REQ_DEC) begin
            tgt = int'(pos);
            for (int i = 0; i < ENTRIES; i++)
               if (i > int'(pos) && OCC_BITS'(i) < occ_ff && !behind[i]) tgt = i;
            for (int i = 0; i < ENTRIES-1; i++)
               if (i >= int'(pos) && i < tgt) begin
                  key_in[i] = key_ff[i+1];
                  cnt_in[i] = cnt_ff[i+1];
               end
            key_in[tgt] = rkey_ff;
            cnt_in[tgt] = nc;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i] <= key_in[i];
         cnt_ff[i] <= cnt_in[i];
      end
      if (op == OP_LOAD) begin
         hit_ff  <= hit_in;
         type_ff <= req.req_type;
         rkey_ff <= KEY_BITS'(req.key);
      end
      if (reset) occ_ff <= '0;
      else       occ_ff <= occ_in;
   end

   always_comb begin
      view.status    = ST_COUNTED;
      view.nonempty  = (occ_ff != '0);
      view.max_key   = view.nonempty ? 32'(key_ff[0]) : '0;
      view.min_key   = view.nonempty ? 32'(key_ff[IDX_BITS'(occ_ff - 1'b1)]) : '0;
      view.max_count = view.nonempty ? 16'(cnt_ff[0]) : '0;
   end

endmodule

// File: design/rkct_control.sv
module rkct_control
   import rkct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   input  dp_status_type stat,
   input  logic          req_type,
   output op_type        op,
   output status_type    status
);

   typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_OUT} state_type;
   state_type  state_ff;
   status_type status_ff, status_in;
   logic       type_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign status    = status_ff;

   always_comb begin
      op = OP_NONE;
      if (state_ff == S_IDLE && req_valid) op = OP_LOAD;
      if (state_ff == S_UPDATE)            op = OP_UPDATE;
   end

   always_comb begin
      priority if (!stat.found)
         status_in = (type_ff == REQ_DEC) ? ST_ABSENT :
                     (stat.full ? ST_FULL : ST_INSERTED);
      else if (type_ff == REQ_DEC && stat.last_one)
         status_in = ST_REMOVED;
      else
         status_in = ST_COUNTED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_UPDATE;
                  type_ff  <= req_type;
               end
            end
            S_UPDATE: begin
               state_ff  <= S_OUT;
               status_ff <= status_in;
            end
            S_OUT: begin
               if (!rsp_stall) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: design/ranked_key_count_table.sv
// flow: the item and its match are registered on load, the table is changed in the update state,
// and the result is held in the output state until taken; a new item is accepted only back in idle
// the match compares all cells at once; the update state shifts all affected cells at once
// reset clears the occupancy and the controller; cell contents are left as they are
module ranked_key_count_table
   import rkct_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type_s_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type_s_type rsp_data
);

   op_type         op;
   dp_status_type  stat;
   rsp_type_s_type view;
   status_type     status;

   rkct_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .rsp_stall, .rsp_valid,
      .stat, .req_type(req_data.req_type), .op, .status
   );

   rkct_datapath u_dp (
      .clock, .reset, .op, .req(req_data), .stat, .view
   );

   always_comb begin
      rsp_data        = view;
      rsp_data.status = status;
   end

endmodule

// File: design/rkct_checker.sv
module rkct_checker
   import rkct_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           req_valid,
   input logic           req_stall,
   input logic           rsp_valid,
   input logic           rsp_stall,
   input rsp_type_s_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.nonempty |-> rsp_data.max_key == '0 && rsp_data.max_count == '0)
      else $error("empty table reports a key");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= 3'd4)
      else $error("bad status");

   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result right after item accepted");

endmodule

bind ranked_key_count_table rkct_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);

// File: test/tb_ranked_key_count_table.sv
module tb_ranked_key_count_table;
   import rkct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class rank_scoreboard;
      logic [31:0] keys[ENTRIES];
      logic [15:0] counts[ENTRIES];
      int unsigned occ;
      rsp_type_s_type pending[$];
      int unsigned errors;

      function void clear_table();
         occ = 0;
         errors = 0;
         pending.delete();
      endfunction

      function void swap_cells(int unsigned a, int unsigned b);
         logic [31:0] k;
         logic [15:0] c;
         k = keys[a];
         c = counts[a];
         keys[a] = keys[b];
         counts[a] = counts[b];
         keys[b] = k;
         counts[b] = c;
      endfunction

      function void note_item(req_type_s_type it);
         int unsigned pos;
         bit found;
         status_type st;
         rsp_type_s_type r;
         pos = 0;
         found = 0;
         st = ST_COUNTED;
         for (int unsigned i = 0; i < occ; i++) begin
            if (!found && keys[i] == it.key) begin
               pos = i;
               found = 1;
            end
         end
         if (it.req_type == REQ_INC) begin
            if (found) begin
               if (counts[pos] != 16'hffff) begin
                  counts[pos]++;
                  while (pos > 0 && counts[pos-1] < counts[pos]) begin
                     swap_cells(pos - 1, pos);
                     pos--;
                  end
               end
               st = ST_COUNTED;
            end else if (occ < ENTRIES) begin
               keys[occ] = it.key;
               counts[occ] = 1;
               occ++;
               st = ST_INSERTED;
            end else begin
               st = ST_FULL;
            end
         end else begin
            if (!found) begin
               st = ST_ABSENT;
            end else if (counts[pos] <= 1) begin
               for (int unsigned i = pos; i + 1 < occ; i++) begin
                  keys[i] = keys[i+1];
                  counts[i] = counts[i+1];
               end
               occ--;
               st = ST_REMOVED;
            end else begin
               counts[pos]--;
               while (pos + 1 < occ && counts[pos+1] > counts[pos]) begin
                  swap_cells(pos, pos + 1);
                  pos++;
               end
               st = ST_COUNTED;
            end
         end
         r = '0;
         r.status = st;
         if (occ > 0) begin
            r.nonempty = 1'b1;
            r.max_key = keys[0];
            r.min_key = keys[occ-1];
            r.max_count = counts[0];
         end
         pending.push_back(r);
      endfunction

      function void check_result(rsp_type_s_type got);
         rsp_type_s_type exp;
         if (pending.size() == 0) begin
            $error("result with nothing expected: %h", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status) begin
            $error("status expected %0d actual %0d", exp.status, got.status);
            errors++;
         end
         if (got.nonempty !== exp.nonempty) begin
            $error("nonempty expected %0d actual %0d", exp.nonempty, got.nonempty);
            errors++;
         end
         if (got.max_key !== exp.max_key) begin
            $error("max_key expected %h actual %h", exp.max_key, got.max_key);
            errors++;
         end
         if (got.min_key !== exp.min_key) begin
            $error("min_key expected %h actual %h", exp.min_key, got.min_key);
            errors++;
         end
         if (got.max_count !== exp.max_count) begin
            $error("max_count expected %0d actual %0d", exp.max_count, got.max_count);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type_s_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type_s_type rsp_data;

   rank_scoreboard sb = new();
   bit hold_on = 1'b0;
   longint unsigned cycles = 0;
   logic [31:0] pool[8];

   ranked_key_count_table DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_item(req_data);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // receiver stall pattern, with a long hold-off each time one is requested
   initial begin
      int unsigned mode;
      int unsigned n;
      @(negedge reset);
      forever begin
         if (hold_on) begin
            @(posedge clock) rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
            hold_on = 1'b0;
         end
         mode = $urandom_range(0, 3);
         n = $urandom_range(1, 30);
         repeat (n) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   int unsigned burst_left = 0;

   task automatic send_item(input logic op, input logic [31:0] k);
      req_type_s_type it;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      it.req_type = op;
      it.key = k;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [31:0] pick_key(input int unsigned npool);
      if ($urandom_range(0, 9) == 0) return $urandom();
      return pool[$urandom_range(0, npool - 1)];
   endfunction

   initial begin
      int unsigned npool;
      sb.clear_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty table, extremes, full, removal
      send_item(REQ_DEC, 32'h0);
      send_item(REQ_INC, 32'h0);
      send_item(REQ_INC, 32'hffffffff);
      send_item(REQ_INC, 32'hffffffff);
      send_item(REQ_DEC, 32'hffffffff);
      send_item(REQ_DEC, 32'h0);
      send_item(REQ_DEC, 32'hffffffff);
      send_item(REQ_DEC, 32'hffffffff);
      for (int i = 0; i < 17; i++) send_item(REQ_INC, 32'h5a5a0000 + i);
      hold_on = 1'b1;
      for (int i = 0; i < 16; i++) send_item(REQ_DEC, 32'h5a5a0000 + i);
      // count one key up repeatedly
      for (int i = 0; i < 24; i++) send_item(REQ_INC, 32'h80000001);
      send_item(REQ_DEC, 32'h80000001);
      send_item(REQ_INC, 32'h80000001);
      // random: small key pools so keys recur and reorder
      for (int b = 0; b < 1150; b++) begin
         if (b % 100 == 0) begin
            npool = $urandom_range(2, 8);
            for (int i = 0; i < 8; i++) pool[i] = $urandom();
            if (b == 500) hold_on = 1'b1;
         end
         send_item(($urandom_range(0, 99) < 40) ? REQ_DEC : REQ_INC, pick_key(npool));
      end
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// File: filelist.f
design/rkct_pkg.sv
design/rkct_datapath.sv
design/rkct_control.sv
design/ranked_key_count_table.sv
design/rkct_checker.sv
test/tb_ranked_key_count_table.sv
